### hdl/dttu_pkg.sv
// Types, constants and character codes shared by the decimal text parser.
`default_nettype none
package dttu_pkg;

    localparam int WIDTH      = 32;
    localparam int MAX_LEN    = 1024;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int VALUE_W    = 32;
    localparam int CONSUMED_W = 11;
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_AW     = $clog2(CMD_DEPTH);

    localparam logic [WIDTH-1:0] MAXV = {WIDTH{1'b1}};
    localparam logic [WIDTH-1:0] CUT  = MAXV / 10;
    localparam logic [3:0]       LIM  = 4'(MAXV % 10);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_DIGIT,
        CLS_MINUS,
        CLS_PLUS,
        CLS_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NON_DIGIT = 2'd1,
        ST_NO_DIGIT  = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       no_char;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic                  value_written;
        status_t               status;
        logic [CONSUMED_W-1:0] consumed;
    } result_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        is_last;
    } cmd_t;

endpackage
`default_nettype wire

### hdl/dttu_front.sv
// Front end: accepts characters and classifies them into commands.
`default_nettype none
module dttu_front (
    input  wire logic           push,
    output logic                full,
    input  wire dttu_pkg::item_t item,
    input  wire logic           cmd_full,
    output logic                cmd_push,
    output dttu_pkg::cmd_t      cmd
);
    import dttu_pkg::*;

    char_class_t cls;

    always_comb
    begin
        if (item.no_char)
        begin
            cls = CLS_NONE;
        end
        else if (item.char_byte >= CH_0 && item.char_byte <= CH_9)
        begin
            cls = CLS_DIGIT;
        end
        else if (item.char_byte == CH_MINUS)
        begin
            cls = CLS_MINUS;
        end
        else if (item.char_byte == CH_PLUS)
        begin
            cls = CLS_PLUS;
        end
        else
        begin
            cls = CLS_OTHER;
        end
    end

    always_comb
    begin
        cmd.cls     = cls;
        cmd.digit   = 4'(item.char_byte - CH_0);
        cmd.is_last = item.is_last;
    end

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

endmodule
`default_nettype wire

### hdl/dttu_cmd_fifo.sv
// Short command queue between front end and back end.
`default_nettype none
module dttu_cmd_fifo (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire dttu_pkg::cmd_t wr_data,
    output logic              full,
    input  wire logic         rd_en,
    output dttu_pkg::cmd_t    rd_data,
    output logic              valid
);
    import dttu_pkg::*;

    cmd_t                slot_reg [CMD_DEPTH];
    logic [CMD_AW-1:0]   wr_ptr_reg;
    logic [CMD_AW-1:0]   wr_ptr_next;
    logic [CMD_AW-1:0]   rd_ptr_reg;
    logic [CMD_AW-1:0]   rd_ptr_next;
    logic [CMD_AW:0]     count_reg;
    logic [CMD_AW:0]     count_next;

    assign full    = (count_reg == (CMD_AW + 1)'(CMD_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### hdl/dttu_back.sv
// Back end: accumulates digits and builds the result word.
`default_nettype none
module dttu_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    input  wire dttu_pkg::cmd_t cmd,
    output logic              cmd_pop,
    output logic              empty,
    input  wire logic         pop,
    output dttu_pkg::result_t result
);
    import dttu_pkg::*;

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             seen_reg;
    logic             seen_next;
    logic             minus_reg;
    logic             minus_next;
    logic             stopped_reg;
    logic             stopped_next;
    logic             first_reg;
    logic             first_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    result_t          res_reg;
    result_t          res_next;

    logic [WIDTH-1:0] acc_times10;
    logic [CNT_W-1:0] cnt_inc;
    logic             too_big;
    logic [WIDTH-1:0] signed_val;

    assign cmd_pop     = cmd_valid && (!cmd.is_last || !res_valid_reg || pop);
    assign empty       = !res_valid_reg;
    assign result      = res_reg;
    assign acc_times10 = (acc_reg << 3) + (acc_reg << 1) + WIDTH'(cmd.digit);
    assign cnt_inc     = (cnt_reg < CNT_W'(MAX_LEN)) ? cnt_reg + 1'b1 : cnt_reg;
    assign too_big     = (acc_reg > CUT) || (acc_reg == CUT && cmd.digit > LIM);

    always_comb
    begin
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        seen_next    = seen_reg;
        minus_next   = minus_reg;
        stopped_next = stopped_reg;
        first_next   = first_reg;
        cnt_next     = cnt_reg;
        if (cmd_pop && cmd.cls != CLS_NONE && !stopped_reg)
        begin
            first_next = 1'b0;
            if (first_reg && cmd.cls == CLS_MINUS)
            begin
                minus_next = 1'b1;
                cnt_next   = cnt_inc;
            end
            else if (first_reg && cmd.cls == CLS_PLUS)
            begin
                cnt_next = cnt_inc;
            end
            else if (cmd.cls == CLS_DIGIT)
            begin
                if (ovf_reg || too_big)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next  = acc_times10;
                    seen_next = 1'b1;
                end
                cnt_next = cnt_inc;
            end
            else
            begin
                stopped_next = 1'b1;
            end
        end
    end

    assign signed_val = minus_next ? (WIDTH'(0) - acc_next) : acc_next;

    always_comb
    begin
        res_next          = res_reg;
        res_next.consumed = CONSUMED_W'(cnt_next);
        if (ovf_next)
        begin
            res_next.value         = VALUE_W'(MAXV);
            res_next.value_written = 1'b1;
            res_next.status        = ST_TOO_LARGE;
        end
        else if (!seen_next && !stopped_next)
        begin
            res_next.value         = '0;
            res_next.value_written = 1'b0;
            res_next.status        = ST_NO_DIGIT;
        end
        else
        begin
            res_next.value         = VALUE_W'(signed_val);
            res_next.value_written = 1'b1;
            res_next.status        = stopped_next ? ST_NON_DIGIT : ST_OK;
        end
    end

    always_comb
    begin
        if (cmd_pop && cmd.is_last)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            minus_reg     <= 1'b0;
            stopped_reg   <= 1'b0;
            first_reg     <= 1'b1;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cmd_pop && cmd.is_last)
            begin
                // restart for the next text
                acc_reg     <= '0;
                ovf_reg     <= 1'b0;
                seen_reg    <= 1'b0;
                minus_reg   <= 1'b0;
                stopped_reg <= 1'b0;
                first_reg   <= 1'b1;
                cnt_reg     <= '0;
            end
            else
            begin
                acc_reg     <= acc_next;
                ovf_reg     <= ovf_next;
                seen_reg    <= seen_next;
                minus_reg   <= minus_next;
                stopped_reg <= stopped_next;
                first_reg   <= first_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.is_last)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

### hdl/decimal_text_to_unsigned_parser_unit.sv
// Top level of the decimal text to unsigned integer parser.
//
// Input channel: one character word per push, accepted when push is high and
// full is low. A word with is_last set closes the text; a word with no_char
// set carries no character. Result channel: one result word per text, shown
// while empty is low and taken when pop is high.
// The word with is_last is first written into the command queue; the back end
// then pops it, registers the result and lowers empty.
// Sustained rate is one character word per cycle while full is low: the front end classifies
// each character, a four-entry command queue feeds the back end, and the
// back end does one multiply-by-ten and add per cycle.
// The back end holds one finished result; while it waits on pop, characters
// of the next text still flow in until the next is_last word, which waits at
// the head of the command queue; three more words fit before full rises.
// Reset empties the queue and the result register and starts a fresh text.
`default_nettype none
module decimal_text_to_unsigned_parser_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire dttu_pkg::item_t item,
    output logic               empty,
    input  wire logic          pop,
    output dttu_pkg::result_t  result
);
    import dttu_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic cmd_push;
    logic cmd_full;
    logic cmd_valid;
    logic cmd_pop;

    dttu_front u_front (
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    dttu_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .valid   (cmd_valid)
    );

    dttu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_no_digit_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.value_written) |->
            (result.status == ST_NO_DIGIT && result.value == '0))
        else $error("unwritten value with wrong status or nonzero value");

    a_too_large_max: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == ST_TOO_LARGE) |-> result.value == VALUE_W'(MAXV))
        else $error("overflow result not saturated");

    a_consumed_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.consumed <= CONSUMED_W'(MAX_LEN))
        else $error("consumed count beyond limit");

endmodule
`default_nettype wire
